>>> design/iou_pkg.sv
// Package for the IoU best-match selector: transfer payload types, the
// sequencer state and the shared multiplier controls. No dependencies.
`timescale 1ns / 1ps

package iou_pkg;

   // Fixed field widths of the request and response transfers.
   localparam int FIELD_BITS = 12;
   localparam int INDEX_BITS = 8;
   localparam int INTER_BITS = 24;
   localparam int UNION_BITS = 25;

   // One candidate against the query box.
   typedef struct packed {
      logic [FIELD_BITS-1:0] query_x;
      logic [FIELD_BITS-1:0] query_y;
      logic [FIELD_BITS-1:0] query_w;
      logic [FIELD_BITS-1:0] query_h;
      logic [FIELD_BITS-1:0] cand_x;
      logic [FIELD_BITS-1:0] cand_y;
      logic [FIELD_BITS-1:0] cand_w;
      logic [FIELD_BITS-1:0] cand_h;
      logic                  last_cand;
   } req_type;

   // Result of one candidate list.
   typedef struct packed {
      logic [INDEX_BITS-1:0] best_index;
      logic                  found;
      logic [INTER_BITS-1:0] best_inter;
      logic [UNION_BITS-1:0] best_union;
      logic                  overflow;
   } rsp_type;

   // Operations of the shared multiplier.
   typedef enum logic [2:0] {
      MUL_QUERY_AREA,
      MUL_CAND_AREA,
      MUL_INTER,
      MUL_LHS,
      MUL_RHS
   } mul_op_type;

   typedef struct packed {
      logic       en;
      mul_op_type op;
   } mul_ctrl_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QAREA,
      ST_CAREA,
      ST_INTER,
      ST_LHS,
      ST_RHS,
      ST_DECIDE,
      ST_OUT
   } state_type;

endpackage

>>> design/iou_mul_unit.sv
// Shared multiplier of the IoU selector with its operand selection and the
// overlap extents of the two boxes. Depends on iou_pkg.
`timescale 1ns / 1ps

module iou_mul_unit #(
   parameter int CW = 12
) (
   input  logic                      clock,
   input  iou_pkg::mul_ctrl_type     ctrl,
   input  iou_pkg::req_type          box,
   input  logic [2*CW-1:0]           inter,
   input  logic [2*CW:0]             uni,
   input  logic [2*CW-1:0]           best_num,
   input  logic [2*CW:0]             best_den,
   output logic [4*CW+1:0]           prod
);

   localparam int EW    = CW + 1;
   localparam int UNI_W = 2 * CW + 1;
   localparam int PROD_W = 2 * UNI_W;

   logic [EW-1:0]     qx0, qy0, qw, qh, cx0, cy0, cw, ch;
   logic [EW-1:0]     qx1, qy1, cx1, cy1;
   logic [EW-1:0]     lo_x, hi_x, lo_y, hi_y;
   logic              overlap;
   logic [EW-1:0]     dx_in, dy_in;
   logic [EW-1:0]     dx_ff, dy_ff;
   logic [UNI_W-1:0]  op_a, op_b;
   logic [PROD_W-1:0] prod_ff;

   // Coordinates keep their low CW bits; far edges get one carry bit.
   always_comb begin
      qx0 = EW'(box.query_x[CW-1:0]);
      qy0 = EW'(box.query_y[CW-1:0]);
      qw  = EW'(box.query_w[CW-1:0]);
      qh  = EW'(box.query_h[CW-1:0]);
      cx0 = EW'(box.cand_x[CW-1:0]);
      cy0 = EW'(box.cand_y[CW-1:0]);
      cw  = EW'(box.cand_w[CW-1:0]);
      ch  = EW'(box.cand_h[CW-1:0]);
      qx1 = qx0 + qw;
      qy1 = qy0 + qh;
      cx1 = cx0 + cw;
      cy1 = cy0 + ch;
   end

   // Overlap extents; separated boxes give zero, touching boxes give zero length.
   always_comb begin
      overlap = !((qx0 > cx1) || (qx1 < cx0) || (qy0 > cy1) || (qy1 < cy0));
      hi_x    = (qx1 < cx1) ? qx1 : cx1;
      lo_x    = (qx0 > cx0) ? qx0 : cx0;
      hi_y    = (qy1 < cy1) ? qy1 : cy1;
      lo_y    = (qy0 > cy0) ? qy0 : cy0;
      dx_in   = overlap ? (hi_x - lo_x) : '0;
      dy_in   = overlap ? (hi_y - lo_y) : '0;
   end

   // Extents are captured alongside the first multiply of an item.
   always_ff @(posedge clock) begin
      if (ctrl.en && ctrl.op == iou_pkg::MUL_QUERY_AREA) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // Operand selection for the single multiplier.
   always_comb begin
      case (ctrl.op)
         iou_pkg::MUL_QUERY_AREA: begin
            op_a = UNI_W'(qw);
            op_b = UNI_W'(qh);
         end
         iou_pkg::MUL_CAND_AREA: begin
            op_a = UNI_W'(cw);
            op_b = UNI_W'(ch);
         end
         iou_pkg::MUL_INTER: begin
            op_a = UNI_W'(dx_ff);
            op_b = UNI_W'(dy_ff);
         end
         iou_pkg::MUL_LHS: begin
            op_a = UNI_W'(inter);
            op_b = best_den;
         end
         iou_pkg::MUL_RHS: begin
            op_a = UNI_W'(best_num);
            op_b = uni;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         prod_ff <= op_a * op_b;
      end
   end

   assign prod = prod_ff;

endmodule

>>> design/iou_best_match_select.sv
// Top level of the IoU best-match selector: sequencer, running best and
// response register. Depends on iou_pkg and iou_mul_unit.
`timescale 1ns / 1ps

// Usage:
// Each request transfer carries the query box, one candidate box and a
// last_cand flag. The block scores the candidate by intersection over union
// and keeps the best one; ratios are compared exactly by cross-multiplying.
// Ties go to the later candidate and a candidate with zero union is skipped.
// On a candidate marked last it sends one response transfer with the best
// index, its areas, a found flag and an overflow flag, then starts a new list.
// Candidates past MAX_CANDIDATES are dropped and raise overflow.
// Sequencing: req_ready drops after a candidate's transfer and returns after
// five passes through the one shared multiplier (two box areas, the
// intersection and both cross products) and the compare. A last candidate
// then loads the response into the output register, after which rsp_valid
// rises and the next candidate can follow. A dropped candidate skips the
// multiplier and the compare; one marked last goes on to load the response.
// A response waiting in the output register does not block new candidates;
// only a second response waits until rsp_ready takes the first.
// Reset clears the running best, the candidate count and rsp_valid.
module iou_best_match_select #(
   parameter int COORD_BITS     = 12,
   parameter int MAX_CANDIDATES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iou_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output iou_pkg::rsp_type rsp_data
);

   localparam int FW     = iou_pkg::FIELD_BITS;
   localparam int CW     = (COORD_BITS < FW) ? COORD_BITS : FW;
   localparam int AREA_W = 2 * CW;
   localparam int UNI_W  = 2 * CW + 1;
   localparam int PROD_W = 2 * UNI_W;
   localparam int NW     = $clog2(MAX_CANDIDATES + 1);
   localparam int PW     = $clog2(MAX_CANDIDATES);
   localparam int IdxW   = iou_pkg::INDEX_BITS;
   localparam int InterW = iou_pkg::INTER_BITS;
   localparam int UnionW = iou_pkg::UNION_BITS;

   iou_pkg::state_type    state_ff, state_in;
   iou_pkg::req_type      box_ff, box_in;
   iou_pkg::mul_ctrl_type mul_ctrl;
   iou_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [NW-1:0]     position_ff, position_in;
   logic [PW-1:0]     best_pos_ff, best_pos_in;
   logic [AREA_W-1:0] best_num_ff, best_num_in;
   logic [UNI_W-1:0]  best_den_ff, best_den_in;
   logic              have_best_ff, have_best_in;
   logic              too_many_ff, too_many_in;

   logic [UNI_W-1:0]  area_ff, area_in;
   logic [AREA_W-1:0] inter_ff, inter_in;
   logic [UNI_W-1:0]  uni_ff, uni_in;
   logic [PROD_W-1:0] lhs_ff, lhs_in;
   logic [PROD_W-1:0] prod;
   logic [AREA_W-1:0] mul_inter;
   logic              take;

   // Shared multiplier; its product is registered inside.
   iou_mul_unit #(
      .CW(CW)
   ) u_mul (
      .clock    (clock),
      .ctrl     (mul_ctrl),
      .box      (box_ff),
      .inter    (mul_inter),
      .uni      (uni_ff),
      .best_num (best_num_ff),
      .best_den (best_den_ff),
      .prod     (prod)
   );

   // The intersection product feeds the left cross product directly.
   assign mul_inter = prod[AREA_W-1:0];
   assign take      = (uni_ff != '0) && (lhs_ff >= prod);

   // Sequencer: next state, running best and response register.
   always_comb begin
      state_in     = state_ff;
      box_in       = box_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      position_in  = position_ff;
      best_pos_in  = best_pos_ff;
      best_num_in  = best_num_ff;
      best_den_in  = best_den_ff;
      have_best_in = have_best_ff;
      too_many_in  = too_many_ff;
      area_in      = area_ff;
      inter_in     = inter_ff;
      uni_in       = uni_ff;
      lhs_in       = lhs_ff;
      mul_ctrl.en  = 1'b0;
      mul_ctrl.op  = iou_pkg::MUL_QUERY_AREA;
      req_ready    = 1'b0;

      case (state_ff)
         iou_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               box_in = req_data;
               if (position_ff == NW'(MAX_CANDIDATES)) begin
                  too_many_in = 1'b1;
                  if (req_data.last_cand) begin
                     state_in = iou_pkg::ST_OUT;
                  end
               end else begin
                  state_in = iou_pkg::ST_QAREA;
               end
            end
         end
         iou_pkg::ST_QAREA: begin
            mul_ctrl.en = 1'b1;
            mul_ctrl.op = iou_pkg::MUL_QUERY_AREA;
            state_in    = iou_pkg::ST_CAREA;
         end
         iou_pkg::ST_CAREA: begin
            mul_ctrl.en = 1'b1;
            mul_ctrl.op = iou_pkg::MUL_CAND_AREA;
            area_in     = prod[UNI_W-1:0];
            state_in    = iou_pkg::ST_INTER;
         end
         iou_pkg::ST_INTER: begin
            mul_ctrl.en = 1'b1;
            mul_ctrl.op = iou_pkg::MUL_INTER;
            area_in     = area_ff + prod[UNI_W-1:0];
            state_in    = iou_pkg::ST_LHS;
         end
         iou_pkg::ST_LHS: begin
            mul_ctrl.en = 1'b1;
            mul_ctrl.op = iou_pkg::MUL_LHS;
            inter_in    = prod[AREA_W-1:0];
            uni_in      = area_ff - prod[UNI_W-1:0];
            state_in    = iou_pkg::ST_RHS;
         end
         iou_pkg::ST_RHS: begin
            mul_ctrl.en = 1'b1;
            mul_ctrl.op = iou_pkg::MUL_RHS;
            lhs_in      = prod;
            state_in    = iou_pkg::ST_DECIDE;
         end
         iou_pkg::ST_DECIDE: begin
            // A tie still takes the candidate, so later ones win.
            if (take) begin
               best_num_in  = inter_ff;
               best_den_in  = uni_ff;
               best_pos_in  = position_ff[PW-1:0];
               have_best_in = 1'b1;
            end
            position_in = position_ff + NW'(1);
            state_in    = box_ff.last_cand ? iou_pkg::ST_OUT : iou_pkg::ST_IDLE;
         end
         iou_pkg::ST_OUT: begin
            // Load the response once the output register is free, then clear.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = have_best_ff;
               rsp_in.best_index  = have_best_ff ? IdxW'(best_pos_ff) : '0;
               rsp_in.best_inter  = have_best_ff ? InterW'(best_num_ff) : '0;
               rsp_in.best_union  = have_best_ff ? UnionW'(best_den_ff) : '0;
               rsp_in.overflow    = too_many_ff;
               position_in        = '0;
               best_pos_in        = '0;
               best_num_in        = '0;
               best_den_in        = UNI_W'(1);
               have_best_in       = 1'b0;
               too_many_in        = 1'b0;
               state_in           = iou_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iou_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iou_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         position_ff  <= '0;
         best_pos_ff  <= '0;
         best_num_ff  <= '0;
         best_den_ff  <= UNI_W'(1);
         have_best_ff <= 1'b0;
         too_many_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         position_ff  <= position_in;
         best_pos_ff  <= best_pos_in;
         best_num_ff  <= best_num_in;
         best_den_ff  <= best_den_in;
         have_best_ff <= have_best_in;
         too_many_ff  <= too_many_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      box_ff   <= box_in;
      rsp_ff   <= rsp_in;
      area_ff  <= area_in;
      inter_ff <= inter_in;
      uni_ff   <= uni_in;
      lhs_ff   <= lhs_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // A reported match always has a nonzero union.
   a_found_union: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.best_union != '0)
      else $error("found response with zero union");

   // With no match, the reported areas and index are zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.best_union == '0 && rsp_data.best_inter == '0 &&
         rsp_data.best_index == '0)
      else $error("empty response carries nonzero fields");

   // The candidate count saturates at the list limit.
   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      position_ff <= NW'(MAX_CANDIDATES))
      else $error("candidate count past limit");

   // The held best ratio never has a zero denominator.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      best_den_ff != '0)
      else $error("best denominator is zero");

   // A non-final candidate returns to idle right after the compare.
   a_decide_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == iou_pkg::ST_DECIDE && !box_ff.last_cand |=>
         state_ff == iou_pkg::ST_IDLE)
      else $error("sequencer did not return to idle");
`endif

endmodule
